@@ sv/lwsp_pkg.sv @@
package lwsp_pkg;

  // action codes carried in the input word
  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_TICKETS = 2'd1,
    ACT_FLAG    = 2'd2,
    ACT_DRAW    = 2'd3
  } action_t;

  // status codes returned in the result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // reported ticket total saturates here
  localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

  // initial ticket count after reset
  localparam logic [15:0] INIT_TICKETS_RST = 16'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [15:0] ticket_value;
    logic        runnable;
    logic [21:0] draw;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  winner_slot;
    logic        winner_valid;
    logic [21:0] ticket_total;
    logic [1:0]  status;
  } res_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic read_slot;
    logic commit;
    logic check;
    logic walk;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic start_draw;
    logic draw_bad;
    logic hit;
  } sts_t;

endpackage

@@ sv/lwsp_ram.sv @@
module lwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lwsp_ctrl.sv @@
module lwsp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lwsp_pkg::sts_t sts,
  output lwsp_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COMMIT,
    S_CHECK,
    S_WALK
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clear_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state <= sts.start_draw ? S_CHECK : S_READ;
        end
        S_READ:   state <= S_COMMIT;
        S_COMMIT: state <= S_IDLE;
        S_CHECK: begin
          state <= sts.draw_bad ? S_IDLE : S_WALK;
        end
        S_WALK: begin
          if (sts.hit) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // command decode
  assign busy          = (state != S_IDLE);
  assign cmd.clear     = (state == S_CLEAR);
  assign cmd.load      = (state == S_IDLE) && start;
  assign cmd.read_slot = (state == S_READ);
  assign cmd.commit    = (state == S_COMMIT);
  assign cmd.check     = (state == S_CHECK);
  assign cmd.walk      = (state == S_WALK);

  // checks
  a_rst_clear: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not enter the clearing pass");
  a_read_commit: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_COMMIT)
    else $error("read not followed by commit");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_READ || state == S_CHECK))
    else $error("accepted word did not start work");

endmodule

@@ sv/lwsp_datapath.sv @@
module lwsp_datapath #(
  parameter int SLOTS       = 64,
  parameter int TICKET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lwsp_pkg::in_word_t  item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  lwsp_pkg::cmd_t      cmd,
  output lwsp_pkg::sts_t      sts,
  output logic                done,
  output lwsp_pkg::res_word_t result
);

  localparam int AW   = $clog2(SLOTS);
  localparam int TOTW = TICKET_BITS + AW;
  localparam int EW   = TICKET_BITS + 1;
  localparam logic [TICKET_BITS-1:0] TMASK = '1;

  logic [15:0]            init_tickets;
  lwsp_pkg::in_word_t     item_q;
  logic [TOTW-1:0]        total;
  logic [TOTW-1:0]        total_next;
  logic [TOTW-1:0]        acc;
  logic [TOTW-1:0]        acc_next;
  logic [AW-1:0]          clr_idx;
  logic [AW-1:0]          walk_idx;
  logic [AW-1:0]          data_idx;
  logic                   data_vld;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;

  logic                   old_run;
  logic [TICKET_BITS-1:0] old_tix;
  logic                   new_run;
  logic [TICKET_BITS-1:0] new_tix;
  logic                   upd;
  logic [1:0]             cmt_status;
  logic [AW-1:0]          slot_addr;
  logic                   in_table;
  logic                   too_wide;
  logic [TOTW-1:0]        old_contrib;
  logic [TOTW-1:0]        new_contrib;
  logic                   hit;
  logic                   draw_bad;
  logic [1:0]             draw_status;

  function automatic logic [21:0] sat_total(input logic [TOTW-1:0] t);
    if (64'(t) > 64'(lwsp_pkg::TOTAL_MAX)) begin
      return lwsp_pkg::TOTAL_MAX;
    end
    return 22'(t);
  endfunction

  // ticket count and runnable flag share one word per slot
  lwsp_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign old_run   = ram_rdata[TICKET_BITS];
  assign old_tix   = ram_rdata[TICKET_BITS-1:0];
  assign slot_addr = AW'(item_q.slot);
  assign in_table  = (32'(item_q.slot) < 32'(SLOTS));
  assign too_wide  = ((item_q.ticket_value >> TICKET_BITS) != 16'd0);

  // new entry for the update actions
  always_comb begin
    new_run    = old_run;
    new_tix    = old_tix;
    upd        = 1'b0;
    cmt_status = lwsp_pkg::ST_OK;
    case (item_q.action)
      lwsp_pkg::ACT_INIT: begin
        new_tix = TICKET_BITS'(init_tickets);
        upd     = in_table;
      end
      lwsp_pkg::ACT_TICKETS: begin
        if (item_q.ticket_value == 16'd0) begin
          cmt_status = lwsp_pkg::ST_ZERO;
        end else begin
          new_tix = too_wide ? TMASK : TICKET_BITS'(item_q.ticket_value);
          upd     = in_table;
        end
      end
      lwsp_pkg::ACT_FLAG: begin
        new_run = item_q.runnable;
        upd     = in_table;
      end
      default: ;
    endcase
  end

  // running total kept up to date on every commit
  assign old_contrib = old_run ? TOTW'(old_tix) : '0;
  assign new_contrib = new_run ? TOTW'(new_tix) : '0;
  assign total_next  = upd ? (total - old_contrib + new_contrib) : total;

  // table port selection
  assign ram_we    = cmd.clear || (cmd.commit && upd);
  assign ram_waddr = cmd.clear ? clr_idx : slot_addr;
  assign ram_wdata = cmd.clear ? '0 : {new_run, new_tix};
  assign ram_raddr = cmd.read_slot ? slot_addr : walk_idx;

  // draw checks and walk step
  assign draw_bad    = (total == '0) || (64'(item_q.draw) >= 64'(total));
  assign draw_status = (total == '0) ? lwsp_pkg::ST_EMPTY : lwsp_pkg::ST_RANGE;
  assign acc_next    = acc + old_contrib;
  assign hit         = data_vld && old_run && (64'(acc_next) > 64'(item_q.draw));

  assign sts.clear_done = (clr_idx == AW'(SLOTS - 1));
  assign sts.start_draw = (item.action == lwsp_pkg::ACT_DRAW);
  assign sts.draw_bad   = draw_bad;
  assign sts.hit        = hit;

  // control state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      init_tickets <= lwsp_pkg::INIT_TICKETS_RST;
      total        <= '0;
      clr_idx      <= '0;
      data_vld     <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) init_tickets <= cfg_data;
      if (cmd.clear) clr_idx <= clr_idx + AW'(1);
      if (cmd.commit) total <= total_next;
      if (cmd.load) begin
        data_vld <= 1'b0;
      end else if (cmd.check || cmd.walk) begin
        data_vld <= 1'b1;
      end
      done <= cmd.commit || (cmd.check && draw_bad) || (cmd.walk && hit);
    end
  end

  // item capture, walk pointers and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q   <= item;
      walk_idx <= '0;
      acc      <= '0;
    end
    if (cmd.check || cmd.walk) begin
      if (walk_idx != AW'(SLOTS - 1)) walk_idx <= walk_idx + AW'(1);
      data_idx <= walk_idx;
    end
    if (cmd.walk && data_vld) acc <= acc_next;
    if (cmd.commit) begin
      result.winner_slot  <= 6'd0;
      result.winner_valid <= 1'b0;
      result.ticket_total <= sat_total(total_next);
      result.status       <= cmt_status;
    end
    if (cmd.check && draw_bad) begin
      result.winner_slot  <= 6'd0;
      result.winner_valid <= 1'b0;
      result.ticket_total <= sat_total(total);
      result.status       <= draw_status;
    end
    if (cmd.walk && hit) begin
      result.winner_slot  <= 6'(data_idx);
      result.winner_valid <= 1'b1;
      result.ticket_total <= sat_total(total);
      result.status       <= lwsp_pkg::ST_OK;
    end
  end

  // checks
  a_win_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.winner_valid) |-> result.status == lwsp_pkg::ST_OK)
    else $error("winner reported with a failure status");
  a_total_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && $past(cmd.walk)) |-> $stable(total))
    else $error("ticket total moved during a draw walk");

endmodule

@@ sv/lottery_weighted_slot_picker_unit.sv @@
// update actions: entry read, then commit; no new word is taken before the commit
// draws: the draw is checked against the total, then the table is walked, one table
//   entry read per cycle from the single read port of the slot table
// reset: a clearing pass zeroes the table, busy stays high meanwhile
// the result is shown for one cycle only; the receiver cannot stall it
module lottery_weighted_slot_picker_unit #(
  parameter int SLOTS       = 64,
  parameter int TICKET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lwsp_pkg::in_word_t  item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output lwsp_pkg::res_word_t result
);

  lwsp_pkg::cmd_t cmd;
  lwsp_pkg::sts_t sts;

  // sequencer
  lwsp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // table, running total and draw walk
  lwsp_datapath #(
    .SLOTS       (SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .result   (result)
  );

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {
    OP_WORD,
    OP_SETUP,
    OP_SETTLE
  } plan_kind_t;

  typedef struct {
    plan_kind_t         kind;
    lwsp_pkg::in_word_t w;
    logic [15:0]        value;
  } plan_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  lwsp_pkg::in_word_t  item = '0;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_data = '0;
  logic                done;
  lwsp_pkg::res_word_t result;

  // predicted copy of the slot table and the initial ticket register
  logic [15:0] slot_tickets [SLOTS];
  logic        slot_live [SLOTS];
  logic [15:0] init_tickets = lwsp_pkg::INIT_TICKETS_RST;

  plan_t               pending_words [$];
  lwsp_pkg::res_word_t awaited_results [$];
  int unsigned n_issued = 0;
  int unsigned n_taken = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off = 0;
  int unsigned calm_left = 0;
  bit          holding = 1'b0;
  logic        send_go;
  logic        send_we;
  lwsp_pkg::res_word_t want;

  lottery_weighted_slot_picker_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_tickets[i] = '0;
      slot_live[i] = 1'b0;
    end
  end

  // sum of tickets over runnable slots
  function automatic int unsigned live_total();
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i]) sum += slot_tickets[i];
    return sum;
  endfunction

  // apply one word to the predicted state and work out its result
  function automatic lwsp_pkg::res_word_t lottery_outcome(lwsp_pkg::in_word_t w);
    lwsp_pkg::res_word_t r;
    int unsigned sum;
    int unsigned acc;
    r = '0;
    r.status = lwsp_pkg::ST_OK;
    case (w.action)
      lwsp_pkg::ACT_INIT: slot_tickets[w.slot] = init_tickets;
      lwsp_pkg::ACT_TICKETS: begin
        if (w.ticket_value == '0) r.status = lwsp_pkg::ST_ZERO;
        else slot_tickets[w.slot] = w.ticket_value;
      end
      lwsp_pkg::ACT_FLAG: slot_live[w.slot] = w.runnable;
      default: ;
    endcase
    sum = live_total();
    r.ticket_total = (sum > lwsp_pkg::TOTAL_MAX) ? lwsp_pkg::TOTAL_MAX : 22'(sum);
    if (w.action == lwsp_pkg::ACT_DRAW) begin
      if (sum == 0) begin
        r.status = lwsp_pkg::ST_EMPTY;
      end else if (w.draw >= sum) begin
        r.status = lwsp_pkg::ST_RANGE;
      end else begin
        // walk in index order, first running sum above the draw wins
        acc = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && !r.winner_valid) begin
            acc += slot_tickets[i];
            if (acc > w.draw) begin
              r.winner_slot = 6'(i);
              r.winner_valid = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // sender gap after each word: mostly short, a few long, some calm stretches
  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  task automatic check_field(string label, logic [21:0] exp_val, logic [21:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, label, exp_val, got_val);
    end
  endtask

  // driver: one word at a time, config writes and settles only when idle
  always @(negedge clk) begin
    if (!rst) begin
      send_go = start;
      send_we = 1'b0;
      if (holding && n_taken == n_issued) begin
        holding = 1'b0;
        send_go = 1'b0;
      end
      if (!holding) begin
        if (hold_off != 0) begin
          hold_off--;
        end else if (pending_words.size() != 0) begin
          case (pending_words[0].kind)
            OP_WORD: begin
              item <= pending_words[0].w;
              send_go = 1'b1;
              holding = 1'b1;
              n_issued++;
              hold_off = next_gap();
              void'(pending_words.pop_front());
            end
            OP_SETUP: begin
              if (awaited_results.size() == 0 && !busy) begin
                cfg_data <= pending_words[0].value;
                send_we = 1'b1;
                void'(pending_words.pop_front());
              end
            end
            default: begin
              if (awaited_results.size() == 0) void'(pending_words.pop_front());
            end
          endcase
        end
      end
      start <= send_go;
      cfg_we <= send_we;
    end
  end

  // monitor: check results first, then take in config and accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got %h", $time, result);
        end else begin
          want = awaited_results.pop_front();
          check_field("winner_slot", 22'(want.winner_slot), 22'(result.winner_slot));
          check_field("winner_valid", 22'(want.winner_valid), 22'(result.winner_valid));
          check_field("ticket_total", want.ticket_total, result.ticket_total);
          check_field("status", 22'(want.status), 22'(result.status));
        end
      end
      if (cfg_we) init_tickets = cfg_data;
      if (start && !busy) begin
        awaited_results.push_back(lottery_outcome(item));
        n_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // word with random filler, the field that matters set from v
  task automatic put(lwsp_pkg::action_t a, int unsigned s, int unsigned v);
    plan_t p;
    p.kind = OP_WORD;
    p.value = '0;
    p.w.action = a;
    p.w.slot = 6'($urandom_range(0, 63));
    p.w.ticket_value = 16'($urandom_range(0, 65535));
    p.w.runnable = 1'($urandom_range(0, 1));
    p.w.draw = 22'($urandom_range(0, 22'h3FFFFF));
    p.w.slot = 6'(s);
    case (a)
      lwsp_pkg::ACT_TICKETS: p.w.ticket_value = 16'(v);
      lwsp_pkg::ACT_FLAG:    p.w.runnable = 1'(v);
      lwsp_pkg::ACT_DRAW:    p.w.draw = 22'(v);
      default: ;
    endcase
    pending_words.push_back(p);
  endtask

  task automatic put_plan(plan_kind_t k, logic [15:0] v);
    plan_t p;
    p.kind = k;
    p.w = '0;
    p.value = v;
    pending_words.push_back(p);
  endtask

  // draw aimed at the current total once every queued word has been taken
  task automatic put_draw();
    int unsigned tot;
    int unsigned r;
    int unsigned d;
    while (pending_words.size() != 0 || n_taken != n_issued) @(negedge clk);
    tot = live_total();
    r = $urandom_range(0, 99);
    if (tot != 0 && r < 75) begin
      r = $urandom_range(0, 9);
      if (r == 0) d = 0;
      else if (r == 1) d = tot - 1;
      else d = $urandom_range(0, tot - 1);
    end else if (r < 88) begin
      d = $urandom_range(tot, 22'h3FFFFF);
    end else begin
      d = $urandom_range(0, 22'h3FFFFF);
    end
    put(lwsp_pkg::ACT_DRAW, $urandom_range(0, 63), d);
  endtask

  task automatic run_phase(logic [15:0] dflt, int unsigned count);
    int unsigned fill;
    int unsigned s;
    int unsigned r;
    put_plan(OP_SETUP, dflt);
    // well-formed start: initialise a set of slots and make them runnable
    fill = (dflt == 16'hFFFF) ? SLOTS : $urandom_range(4, 16);
    for (int k = 0; k < fill; k++) begin
      s = (fill == SLOTS) ? k : $urandom_range(0, 63);
      put(lwsp_pkg::ACT_INIT, s, 0);
      put(lwsp_pkg::ACT_FLAG, s, 1);
    end
    for (int k = 0; k < count; k++) begin
      s = $urandom_range(0, 63);
      r = $urandom_range(0, 99);
      if (r < 2) put_plan(OP_SETTLE, '0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        put(lwsp_pkg::ACT_INIT, s, 0);
      end else if (r < 35) begin
        r = $urandom_range(0, 9);
        if (r == 0) put(lwsp_pkg::ACT_TICKETS, s, 0);
        else if (r == 1) put(lwsp_pkg::ACT_TICKETS, s, 65535);
        else if (r == 2) put(lwsp_pkg::ACT_TICKETS, s, $urandom_range(1, 15));
        else put(lwsp_pkg::ACT_TICKETS, s, $urandom_range(1, 65535));
      end else if (r < 55) begin
        put(lwsp_pkg::ACT_FLAG, s, ($urandom_range(0, 9) < 6) ? 1 : 0);
      end else begin
        put_draw();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty draw, initialise, zero write, range edges, flag kept
    put(lwsp_pkg::ACT_DRAW, 0, 0);
    put(lwsp_pkg::ACT_INIT, 0, 0);
    put(lwsp_pkg::ACT_FLAG, 0, 1);
    put(lwsp_pkg::ACT_DRAW, 0, 9);
    put(lwsp_pkg::ACT_DRAW, 0, 10);
    put(lwsp_pkg::ACT_TICKETS, 63, 0);
    put(lwsp_pkg::ACT_TICKETS, 63, 65535);
    put(lwsp_pkg::ACT_FLAG, 63, 1);
    put(lwsp_pkg::ACT_DRAW, 0, 10);
    put(lwsp_pkg::ACT_DRAW, 0, 22'h3FFFFF);
    put(lwsp_pkg::ACT_FLAG, 0, 0);
    put(lwsp_pkg::ACT_INIT, 63, 0);
    put(lwsp_pkg::ACT_DRAW, 0, 0);
    put(lwsp_pkg::ACT_TICKETS, 42, 1);
    put(lwsp_pkg::ACT_FLAG, 42, 1);
    put(lwsp_pkg::ACT_DRAW, 0, 10);
    put(lwsp_pkg::ACT_DRAW, 0, 0);
    // zero initial count: the initialised slot can never win
    put_plan(OP_SETUP, 16'd0);
    put(lwsp_pkg::ACT_INIT, 5, 0);
    put(lwsp_pkg::ACT_FLAG, 5, 1);
    put(lwsp_pkg::ACT_DRAW, 0, 0);
    put(lwsp_pkg::ACT_FLAG, 5, 0);
    put_plan(OP_SETTLE, '0);

    // random phases over several initial counts
    run_phase(16'hFFFF, 170);
    run_phase(16'd1, 170);
    run_phase(16'd0, 170);
    run_phase(16'($urandom_range(1, 65535)), 170);
    run_phase(lwsp_pkg::INIT_TICKETS_RST, 170);
    run_phase(16'($urandom_range(1, 65535)), 170);
    run_phase(16'($urandom_range(1, 255)), 170);

    while (pending_words.size() != 0 || n_taken != n_issued || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lwsp_pkg.sv
sv/lwsp_ram.sv
sv/lwsp_ctrl.sv
sv/lwsp_datapath.sv
sv/lottery_weighted_slot_picker_unit.sv
test/testbench.sv
